// ===== rtl/qrsuv_pkg.sv =====
// qrsuv_pkg: shared constants, register codes and the arctangent table
`timescale 1ns / 1ps
`default_nettype none
package qrsuv_pkg;

	localparam int QW           = 16;
	localparam int ANGLE_STAGES = 16;
	localparam int ANG_ITERS    = (ANGLE_STAGES > 24) ? 24 : ANGLE_STAGES;

	localparam int MAT_W  = 35;
	localparam int PROD_W = 51;
	localparam int SUM_W  = 53;
	localparam int LON_W  = 42;
	localparam int LAT_W  = 32;
	localparam int ANG_W  = 32;

	localparam int SQ_STEPS = 29;
	localparam int ROOT_W   = 29;
	localparam int REM_W    = 59;

	localparam int U_W = 15;
	localparam int V_W = 16;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = 2'd3;

	localparam logic signed [QW-1:0] QUAT_ONE = 16'sd16384;
	localparam logic signed [QW-1:0] Y_MAX    = 16'sd16384;
	localparam logic signed [QW-1:0] Y_MIN    = -16'sd16384;

	// atan(2^-i) in binary turns, 2^32 per turn
	function automatic logic [ANG_W-1:0] atan_turn(input int i);
		logic [ANG_W-1:0] r;
		case (i)
			0:  r = 32'h20000000;
			1:  r = 32'h12E4051E;
			2:  r = 32'h09FB385B;
			3:  r = 32'h051111D4;
			4:  r = 32'h028B0D43;
			5:  r = 32'h0145D7E1;
			6:  r = 32'h00A2F61E;
			7:  r = 32'h00517C55;
			8:  r = 32'h0028BE53;
			9:  r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/quaternion_rotate_to_sphere_uv.sv =====
// quaternion_rotate_to_sphere_uv: rotate a sphere point and map it to equirectangular u/v
`timescale 1ns / 1ps
`default_nettype none
// Rotates each unit-sphere point (signed Q1.14) by the quaternion held in the four
// configuration registers and returns equirectangular texture coordinates: tex_u is the
// wrapped longitude (unsigned Q0.15), tex_v the clamped latitude (0..32768). The block is a
// fixed pipeline that takes one item per clock and holds no state between items. The
// longitude CORDIC, the one-bit-per-stage square root for the latitude cosine and the
// latitude CORDIC run one after the other. The whole pipeline advances together whenever
// the output register is empty or being taken, so a stall on the output side holds every
// stage. The rotation matrix is rebuilt in two register steps after a configuration write
// and is ready before the first item that follows the write reaches the multipliers.
module quaternion_rotate_to_sphere_uv
	import qrsuv_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [47:0]          s_tdata,   // pos_x, pos_y, pos_z
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [31:0]               m_tdata,   // tex_u, tex_v, zero pad
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [QW-1:0]        cfg_data
);

	localparam logic signed [MAT_W-1:0] ONE_MAT = MAT_W'(64'sd268435456);

	// global advance: every stage moves when the output register can take a new item
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// configuration registers
	logic signed [QW-1:0] qw_q, qx_q, qy_q, qz_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qw_q <= QUAT_ONE;
			qx_q <= '0;
			qy_q <= '0;
			qz_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_QUAT_W: qw_q <= cfg_data;
				REG_QUAT_X: qx_q <= cfg_data;
				REG_QUAT_Y: qy_q <= cfg_data;
				REG_QUAT_Z: qz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// quaternion products, then matrix entries (Q.28), both follow the registers continuously
	logic signed [31:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
	always_ff @(posedge clk) begin
		xx_q <= qx_q * qx_q;
		yy_q <= qy_q * qy_q;
		zz_q <= qz_q * qz_q;
		xy_q <= qx_q * qy_q;
		xz_q <= qx_q * qz_q;
		yz_q <= qy_q * qz_q;
		wx_q <= qw_q * qx_q;
		wy_q <= qw_q * qy_q;
		wz_q <= qw_q * qz_q;
	end

	logic signed [MAT_W-1:0] m00_q, m01_q, m02_q, m10_q, m11_q, m12_q, m20_q, m21_q, m22_q;
	always_ff @(posedge clk) begin
		m00_q <= ONE_MAT - ((MAT_W'(yy_q) + MAT_W'(zz_q)) <<< 1);
		m01_q <= (MAT_W'(xy_q) - MAT_W'(wz_q)) <<< 1;
		m02_q <= (MAT_W'(xz_q) + MAT_W'(wy_q)) <<< 1;
		m10_q <= (MAT_W'(xy_q) + MAT_W'(wz_q)) <<< 1;
		m11_q <= ONE_MAT - ((MAT_W'(xx_q) + MAT_W'(zz_q)) <<< 1);
		m12_q <= (MAT_W'(yz_q) - MAT_W'(wx_q)) <<< 1;
		m20_q <= (MAT_W'(xz_q) - MAT_W'(wy_q)) <<< 1;
		m21_q <= (MAT_W'(yz_q) + MAT_W'(wx_q)) <<< 1;
		m22_q <= ONE_MAT - ((MAT_W'(xx_q) + MAT_W'(yy_q)) <<< 1);
	end

	// s1/s2: input capture and a wait for the matrix
	logic                 v_s1, v_s2;
	logic signed [QW-1:0] px_s1, py_s1, pz_s1, px_s2, py_s2, pz_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= s_tdata[15:0];
			py_s1 <= s_tdata[31:16];
			pz_s1 <= s_tdata[47:32];
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			pz_s2 <= pz_s1;
		end
	end

	// s3: nine products
	logic                     v_s3;
	logic signed [PROD_W-1:0] p00_s3, p01_s3, p02_s3, p10_s3, p11_s3, p12_s3;
	logic signed [PROD_W-1:0] p20_s3, p21_s3, p22_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			p00_s3 <= PROD_W'(px_s2) * PROD_W'(m00_q);
			p01_s3 <= PROD_W'(py_s2) * PROD_W'(m01_q);
			p02_s3 <= PROD_W'(pz_s2) * PROD_W'(m02_q);
			p10_s3 <= PROD_W'(px_s2) * PROD_W'(m10_q);
			p11_s3 <= PROD_W'(py_s2) * PROD_W'(m11_q);
			p12_s3 <= PROD_W'(pz_s2) * PROD_W'(m12_q);
			p20_s3 <= PROD_W'(px_s2) * PROD_W'(m20_q);
			p21_s3 <= PROD_W'(py_s2) * PROD_W'(m21_q);
			p22_s3 <= PROD_W'(pz_s2) * PROD_W'(m22_q);
		end
	end

	// s4: rotated point, exact Q.42
	logic                    v_s4;
	logic signed [SUM_W-1:0] rx_s4, ry_s4, rz_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			rx_s4 <= SUM_W'(p00_s3) + SUM_W'(p01_s3) + SUM_W'(p02_s3);
			ry_s4 <= SUM_W'(p10_s3) + SUM_W'(p11_s3) + SUM_W'(p12_s3);
			rz_s4 <= SUM_W'(p20_s3) + SUM_W'(p21_s3) + SUM_W'(p22_s3);
		end
	end

	// s5: round x, z to Q.28 and y to Q.14 with saturation
	logic signed [SUM_W-1:0] rx_rnd, rz_rnd, ry_rnd;
	assign rx_rnd = (rx_s4 + SUM_W'(64'sd8192)) >>> 14;
	assign rz_rnd = (rz_s4 + SUM_W'(64'sd8192)) >>> 14;
	assign ry_rnd = (ry_s4 + SUM_W'(64'sd134217728)) >>> 28;

	logic                    v_s5;
	logic signed [LON_W-1:0] lre_s5, lim_s5;
	logic signed [QW-1:0]    ys_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			lre_s5 <= LON_W'(rz_rnd);
			lim_s5 <= LON_W'(rx_rnd);
			if (ry_rnd > SUM_W'(Y_MAX))
				ys_s5 <= Y_MAX;
			else if (ry_rnd < SUM_W'(Y_MIN))
				ys_s5 <= Y_MIN;
			else
				ys_s5 <= QW'(ry_rnd);
		end
	end

	// longitude cordic: entry [0] is the half-turn fold, [g+1] is after iteration g
	logic                    lv_s   [ANG_ITERS+1];
	logic signed [LON_W-1:0] lre_s  [ANG_ITERS+1];
	logic signed [LON_W-1:0] lim_s  [ANG_ITERS+1];
	logic [ANG_W-1:0]        lang_s [ANG_ITERS+1];
	logic signed [QW-1:0]    lys_s  [ANG_ITERS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			lys_s[0] <= ys_s5;
			if (lre_s5 < 0) begin
				lre_s[0]  <= -lre_s5;
				lim_s[0]  <= -lim_s5;
				lang_s[0] <= 32'h80000000;
			end else begin
				lre_s[0]  <= lre_s5;
				lim_s[0]  <= lim_s5;
				lang_s[0] <= '0;
			end
		end
	end

	for (genvar g = 0; g < ANG_ITERS; g++) begin : g_lon
		always_ff @(posedge clk) begin
			if (en) begin
				lys_s[g+1] <= lys_s[g];
				if (lim_s[g] == 0) begin
					lre_s[g+1]  <= lre_s[g];
					lim_s[g+1]  <= lim_s[g];
					lang_s[g+1] <= lang_s[g];
				end else if (lim_s[g] > 0) begin
					lre_s[g+1]  <= lre_s[g] + (lim_s[g] >>> g);
					lim_s[g+1]  <= lim_s[g] - (lre_s[g] >>> g);
					lang_s[g+1] <= lang_s[g] + atan_turn(g);
				end else begin
					lre_s[g+1]  <= lre_s[g] - (lim_s[g] >>> g);
					lim_s[g+1]  <= lim_s[g] + (lre_s[g] >>> g);
					lang_s[g+1] <= lang_s[g] - atan_turn(g);
				end
			end
		end
	end

	// u from the longitude, and the radicand (1 - y^2) at Q.56
	logic [ANG_W-1:0]     uturn, urnd;
	logic signed [31:0]   ysq;
	assign uturn = lang_s[ANG_ITERS] + 32'h80000000;
	assign urnd  = uturn + 32'h00010000;
	assign ysq   = lys_s[ANG_ITERS] * lys_s[ANG_ITERS];

	// square root: entry [0] holds the radicand, [g+1] is after result bit SQ_STEPS-1-g
	logic                 qv_s    [SQ_STEPS+1];
	logic [REM_W-1:0]     qrem_s  [SQ_STEPS+1];
	logic [ROOT_W-1:0]    qroot_s [SQ_STEPS+1];
	logic [U_W-1:0]       qu_s    [SQ_STEPS+1];
	logic signed [QW-1:0] qys_s   [SQ_STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			qrem_s[0]  <= (REM_W'(33'sd268435456 - 33'(ysq))) << 28;
			qroot_s[0] <= '0;
			qu_s[0]    <= urnd[31:17];
			qys_s[0]   <= lys_s[ANG_ITERS];
		end
	end

	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
		localparam int B = SQ_STEPS - 1 - g;
		logic [REM_W-1:0] trial;
		assign trial = (REM_W'(qroot_s[g]) << (B + 1)) + (REM_W'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if (en) begin
				qu_s[g+1]  <= qu_s[g];
				qys_s[g+1] <= qys_s[g];
				if (qrem_s[g] >= trial) begin
					qrem_s[g+1]  <= qrem_s[g] - trial;
					qroot_s[g+1] <= qroot_s[g] | (ROOT_W'(1) << B);
				end else begin
					qrem_s[g+1]  <= qrem_s[g];
					qroot_s[g+1] <= qroot_s[g];
				end
			end
		end
	end

	// latitude cordic on (cos, sin); the cosine is never negative so no fold
	logic                    av_s   [ANG_ITERS+1];
	logic signed [LAT_W-1:0] are_s  [ANG_ITERS+1];
	logic signed [LAT_W-1:0] aim_s  [ANG_ITERS+1];
	logic [ANG_W-1:0]        aang_s [ANG_ITERS+1];
	logic [U_W-1:0]          au_s   [ANG_ITERS+1];

	always_comb begin
		are_s[0]  = LAT_W'(qroot_s[SQ_STEPS]);
		aim_s[0]  = LAT_W'(qys_s[SQ_STEPS]) <<< 14;
		aang_s[0] = '0;
		au_s[0]   = qu_s[SQ_STEPS];
		av_s[0]   = qv_s[SQ_STEPS];
	end

	for (genvar g = 0; g < ANG_ITERS; g++) begin : g_lat
		always_ff @(posedge clk) begin
			if (en) begin
				au_s[g+1] <= au_s[g];
				if (aim_s[g] == 0) begin
					are_s[g+1]  <= are_s[g];
					aim_s[g+1]  <= aim_s[g];
					aang_s[g+1] <= aang_s[g];
				end else if (aim_s[g] > 0) begin
					are_s[g+1]  <= are_s[g] + (aim_s[g] >>> g);
					aim_s[g+1]  <= aim_s[g] - (are_s[g] >>> g);
					aang_s[g+1] <= aang_s[g] + atan_turn(g);
				end else begin
					are_s[g+1]  <= are_s[g] - (aim_s[g] >>> g);
					aim_s[g+1]  <= aim_s[g] + (are_s[g] >>> g);
					aang_s[g+1] <= aang_s[g] - atan_turn(g);
				end
			end
		end
	end

	// v = (2*phi + half turn + rounding) >> 17, clamped to [0, 32768]
	logic signed [34:0] tv;
	logic signed [34:0] tv_sh;
	logic [V_W-1:0]     tex_v_w;
	assign tv    = (35'(signed'(aang_s[ANG_ITERS])) <<< 1) + 35'sh080000000 + 35'sh000010000;
	assign tv_sh = tv >>> 17;
	always_comb begin
		if (tv < 0)
			tex_v_w = '0;
		else if (tv_sh > 35'sd32768)
			tex_v_w = 16'd32768;
		else
			tex_v_w = tv_sh[V_W-1:0];
	end

	// output register
	logic [U_W-1:0] tex_u_q;
	logic [V_W-1:0] tex_v_q;
	always_ff @(posedge clk) begin
		if (en) begin
			tex_u_q <= au_s[ANG_ITERS];
			tex_v_q <= tex_v_w;
		end
	end
	assign m_tdata = {1'b0, tex_v_q, tex_u_q};

	// valid bits travel with the items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_s1     <= s_tvalid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			v_s5     <= v_s4;
			m_tvalid <= av_s[ANG_ITERS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lv_s[0] <= 1'b0;
			qv_s[0] <= 1'b0;
		end else if (en) begin
			lv_s[0] <= v_s5;
			qv_s[0] <= lv_s[ANG_ITERS];
		end
	end

	for (genvar g = 0; g < ANG_ITERS; g++) begin : g_lv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lv_s[g+1] <= 1'b0;
				av_s[g+1] <= 1'b0;
			end else if (en) begin
				lv_s[g+1] <= lv_s[g];
				av_s[g+1] <= av_s[g];
			end
		end
	end

	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_qv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				qv_s[g+1] <= 1'b0;
			else if (en)
				qv_s[g+1] <= qv_s[g];
		end
	end

	// latitude coordinate never exceeds one
	a_v_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[30:15] <= 16'd32768)
		else $error("tex_v above one");

	// saturated y stays on the unit range
	a_y_sat: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (ys_s5 <= Y_MAX) && (ys_s5 >= Y_MIN))
		else $error("latitude input not saturated");

	// square-root result never exceeds one at Q.28
	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qv_s[SQ_STEPS] |-> qroot_s[SQ_STEPS] <= ROOT_W'(268435456))
		else $error("cosine out of range");

	// a held output stays put while the pipeline is frozen
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && m_tvalid)
		else $error("output changed while stalled");

endmodule
`default_nettype wire
